>>> rtl/potb_pkg.sv
package potb_pkg;

  localparam int FUNC_W = 3;
  localparam int IDX_W  = 3;
  localparam int ST_W   = 2;
  localparam int KIND_W = 2;
  localparam int INFO_W = 32;

  localparam int IDX_COUNT = 1 << IDX_W;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam logic [FUNC_W-1:0] FN_INIT    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_START   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STOP    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_INFO    = 3'd5;

  localparam logic [ST_W-1:0] ST_CREATED   = 2'd0;
  localparam logic [ST_W-1:0] ST_STARTED   = 2'd1;
  localparam logic [ST_W-1:0] ST_STOPPED   = 2'd2;
  localparam logic [ST_W-1:0] ST_DESTROYED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INFO  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [INFO_W-1:0] start_delay;
    logic [INFO_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic            fire;
    logic [ST_W-1:0] status;
  } fire_t;

endpackage

>>> rtl/potb_cell.sv
module potb_cell
  import potb_pkg::*;
#(
  parameter int CNT_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic             cmd_we,
  input  logic             step,
  input  logic             tok_prev,
  output logic             tok_o,
  output logic [ST_W-1:0]  st_nxt_o,
  output logic [CNT_W-1:0] sd_o,
  output logic [CNT_W-1:0] per_o,
  output fire_t            fire_o
);

  logic [ST_W-1:0]  st_r, st_nxt;
  logic             tok_r, tok_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sd_r, sd_nxt;
  logic [CNT_W-1:0] per_r, per_nxt;
  logic [CNT_W-1:0] reload;
  logic [CNT_W-1:0] new_sd, new_per;
  logic             expire;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    sd_nxt  = sd_r;
    per_nxt = per_r;
    reload  = (sd_r != '0) ? sd_r : per_r;
    new_sd  = cmd.start_delay[CNT_W-1:0];
    new_per = cmd.period[CNT_W-1:0];
    expire  = (st_r == ST_STARTED) && (cnt_r <= CNT_W'(1));
    tok_nxt = step ? tok_prev : tok_r;
    if (cmd_we) begin
      unique case (cmd.func)
        FN_INIT: begin
          sd_nxt  = new_sd;
          per_nxt = new_per;
          cnt_nxt = (new_sd != '0) ? new_sd : new_per;
          st_nxt  = ST_CREATED;
        end
        FN_START: begin
          if (st_r == ST_CREATED || st_r == ST_STOPPED) begin
            cnt_nxt = reload;
            st_nxt  = ST_STARTED;
          end
        end
        FN_STOP: begin
          if (st_r == ST_STARTED) begin
            st_nxt = ST_STOPPED;
          end
        end
        FN_DESTROY: begin
          st_nxt = ST_DESTROYED;
        end
        default: ;
      endcase
    end else if (tok_r && step && st_r == ST_STARTED) begin
      if (expire) begin
        if (per_r != '0) begin
          cnt_nxt = per_r;
        end else begin
          cnt_nxt = '0;
          st_nxt  = ST_STOPPED;
        end
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_DESTROYED;
      tok_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      tok_r <= tok_nxt;
    end
    cnt_r <= cnt_nxt;
    sd_r  <= sd_nxt;
    per_r <= per_nxt;
  end

  assign tok_o         = tok_r;
  assign st_nxt_o      = st_nxt;
  assign sd_o          = sd_r;
  assign per_o         = per_r;
  assign fire_o.fire   = tok_r && expire;
  assign fire_o.status = (per_r != '0) ? ST_STARTED : ST_STOPPED;

endmodule

>>> rtl/periodic_one_shot_timer_bank.sv
// Bank of NUM_TIMERS tick timers built as a row of cells, one per timer.
// Init, start, stop, destroy and info each answer with a single transfer;
// a new command is taken every cycle while the result register is free.
// A tick sends a token down the row, one cell per cycle while the result
// register is free: each started timer that expires gives a fire transfer
// in index order, and a done transfer with tlast closes the tick. No
// command is taken during a walk.
module periodic_one_shot_timer_bank
  import potb_pkg::*;
#(
  parameter int NUM_TIMERS = 8,
  parameter int TICK_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // timer_index, start_delay, period, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [FUNC_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // which_timer, timer_status, info_start_delay, info_period, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  localparam int CNT_W = (TICK_WIDTH < INFO_W) ? TICK_WIDTH : INFO_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t            state_r;
  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [IDX_W-1:0]  which_r;
  logic [ST_W-1:0]   status_r;
  logic [INFO_W-1:0] info_sd_r, info_per_r;
  logic              last_r;

  cmd_t              cmd;
  logic [IDX_W-1:0]  idx;
  logic              idx_ok;
  logic              slot_free, in_xfer, inject, is_tick;

  logic [NUM_TIMERS-1:0] sel, cmd_we, tok, tok_in;
  logic [ST_W-1:0]       st_nxt [NUM_TIMERS];
  logic [CNT_W-1:0]      sd     [NUM_TIMERS];
  logic [CNT_W-1:0]      per    [NUM_TIMERS];
  fire_t                 fire   [NUM_TIMERS];

  logic              fire_any;
  logic [IDX_W-1:0]  fire_idx;
  logic [ST_W-1:0]   fire_st;
  logic [ST_W-1:0]   rd_st;
  logic [CNT_W-1:0]  rd_sd, rd_per;
  logic [ST_W-1:0]   cmd_st;
  logic [INFO_W-1:0] cmd_sd, cmd_per;

  assign idx             = in_tdata[IDX_W-1:0];
  assign cmd.func        = in_tuser;
  assign cmd.start_delay = in_tdata[IDX_W +: INFO_W];
  assign cmd.period      = in_tdata[IDX_W+INFO_W +: INFO_W];
  assign idx_ok          = int'(idx) < NUM_TIMERS;
  assign is_tick         = (cmd.func == FN_TICK);

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign inject    = in_xfer && is_tick;

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      sel[i]    = (i < IDX_COUNT) && (idx == IDX_W'(i));
      cmd_we[i] = in_xfer && !is_tick && sel[i];
      tok_in[i] = (i == 0) ? inject : tok[(i == 0) ? 0 : i - 1];
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    potb_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .cmd_we  (cmd_we[g]),
      .step    (slot_free),
      .tok_prev(tok_in[g]),
      .tok_o   (tok[g]),
      .st_nxt_o(st_nxt[g]),
      .sd_o    (sd[g]),
      .per_o   (per[g]),
      .fire_o  (fire[g])
    );
  end

  always_comb begin
    fire_any = 1'b0;
    fire_idx = '0;
    fire_st  = '0;
    rd_st    = '0;
    rd_sd    = '0;
    rd_per   = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (fire[i].fire) begin
        fire_any = 1'b1;
        fire_idx = fire_idx | IDX_W'(i);
        fire_st  = fire_st | fire[i].status;
      end
      if (sel[i]) begin
        rd_st  = rd_st | st_nxt[i];
        rd_sd  = rd_sd | sd[i];
        rd_per = rd_per | per[i];
      end
    end
    cmd_st  = idx_ok ? rd_st : ST_DESTROYED;
    cmd_sd  = (idx_ok && cmd.func == FN_INFO) ? INFO_W'(rd_sd) : '0;
    cmd_per = (idx_ok && cmd.func == FN_INFO) ? INFO_W'(rd_per) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (is_tick) begin
              state_r <= S_WALK;
            end else begin
              out_valid_r <= 1'b1;
              kind_r      <= (cmd.func == FN_INFO) ? KIND_INFO : KIND_DONE;
              which_r     <= idx;
              status_r    <= cmd_st;
              info_sd_r   <= cmd_sd;
              info_per_r  <= cmd_per;
              last_r      <= 1'b1;
            end
          end
        end
        S_WALK: begin
          if (slot_free && fire_any) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_FIRED;
            which_r     <= fire_idx;
            status_r    <= fire_st;
            info_sd_r   <= '0;
            info_per_r  <= '0;
            last_r      <= 1'b0;
          end
          if (slot_free && tok[NUM_TIMERS-1]) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_DONE;
            which_r     <= '0;
            status_r    <= ST_CREATED;
            info_sd_r   <= '0;
            info_per_r  <= '0;
            last_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_DATA_W - IDX_W - ST_W - 2*INFO_W){1'b0}},
                       info_per_r, info_sd_r, status_r, which_r};

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one walk token in the row");

  a_ready_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (tok == '0))
    else $error("input ready while a tick walk is in flight");

  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_FIRED) |-> !last_r)
    else $error("fire transfer marked last");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && slot_free && tok[NUM_TIMERS-1]) |=> state_r == S_DONE)
    else $error("tick walk did not close");
`endif

endmodule
